@@ src/ali_pkg.sv @@
`default_nettype none
package ali_pkg;

  localparam int unsigned DEPTH_DEF = 256;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_INSERT = 3'd4,
    OP_ERASE  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         position;
    logic signed [31:0] word_in;
  } req_t;

  typedef struct packed {
    logic signed [31:0] word_out;
    logic [8:0]         count_now;
    logic [1:0]         status;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic shift_start;
    logic shift_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic shift_needed;
    logic shift_last;
    logic can_load;
  } stat_t;

endpackage
`default_nettype wire

@@ src/ali_ctrl.sv @@
`default_nettype none
module ali_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire ali_pkg::stat_t stat,
  output ali_pkg::cmd_t      cmd
);

  ali_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ali_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_ready = 1'b0;
    unique case (state)
      ali_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next = ali_pkg::S_EXEC;
        end
      end
      ali_pkg::S_EXEC: begin
        if (stat.shift_needed) begin
          cmd.shift_start = 1'b1;
          state_next = ali_pkg::S_SHIFT;
        end else if (stat.can_load) begin
          cmd.commit = 1'b1;
          state_next = ali_pkg::S_IDLE;
        end
      end
      ali_pkg::S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_last) begin
          state_next = ali_pkg::S_DONE;
        end
      end
      ali_pkg::S_DONE: begin
        if (stat.can_load) begin
          cmd.commit = 1'b1;
          state_next = ali_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ali_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/ali_dpath.sv @@
`default_nettype none
module ali_dpath #(
  parameter int unsigned DEPTH = ali_pkg::DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ali_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output ali_pkg::rsp_t       rsp,
  input  wire ali_pkg::cmd_t  cmd,
  output ali_pkg::stat_t      stat
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > 8) ? CW : 8;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_data;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  ali_pkg::req_t cur;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] wptr, wptr_next;

  logic [CMPW:0] pos_w, cnt_w;
  logic [AW-1:0] pos_a;
  logic          is_full, is_empty;
  logic          pos_lt_cnt, pos_le_cnt;

  ali_pkg::rsp_t rsp_next;

  assign pos_w      = (CMPW + 1)'(cur.position);
  assign cnt_w      = (CMPW + 1)'(count);
  assign pos_a      = AW'(cur.position);
  assign is_full    = (count == CW'(DEPTH));
  assign is_empty   = (count == '0);
  assign pos_lt_cnt = (pos_w < cnt_w);
  assign pos_le_cnt = (pos_w <= cnt_w);

  always_comb begin
    stat = '0;
    stat.can_load = !rsp_valid || rsp_ready;
    case (cur.opcode)
      ali_pkg::OP_INSERT: begin
        stat.shift_needed = pos_lt_cnt && !is_full;
        stat.shift_last   = ((AW + 1)'(wptr) == (AW + 1)'(pos_a) + (AW + 1)'(1));
      end
      ali_pkg::OP_ERASE: begin
        stat.shift_needed = (pos_w + (CMPW + 1)'(1)) < cnt_w;
        stat.shift_last   = ((CW + 1)'(wptr) + (CW + 1)'(2) == (CW + 1)'(count));
      end
      default: begin
      end
    endcase
  end

  // memory port selection, shift pointer, next count and response
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = cur.word_in;
    wptr_next = wptr;
    count_next = count;
    rsp_next  = '0;
    if (cmd.capture) begin
      mem_re    = 1'b1;
      mem_raddr = AW'(req.position);
    end
    if (cmd.shift_start) begin
      mem_re = 1'b1;
      if (cur.opcode == ali_pkg::OP_INSERT) begin
        mem_raddr = AW'(count - CW'(1));
        wptr_next = AW'(count);
      end else begin
        mem_raddr = pos_a + AW'(1);
        wptr_next = pos_a;
      end
    end
    if (cmd.shift_step) begin
      mem_we    = 1'b1;
      mem_waddr = wptr;
      mem_wdata = rd_data;
      mem_re    = 1'b1;
      if (cur.opcode == ali_pkg::OP_INSERT) begin
        mem_raddr = wptr - AW'(2);
        wptr_next = wptr - AW'(1);
      end else begin
        mem_raddr = wptr + AW'(2);
        wptr_next = wptr + AW'(1);
      end
    end
    if (cmd.commit) begin
      rsp_next.status = ali_pkg::ST_OK;
      case (cur.opcode)
        ali_pkg::OP_APPEND: begin
          if (is_full) begin
            rsp_next.status = ali_pkg::ST_FULL;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = AW'(count);
            count_next = count + CW'(1);
          end
        end
        ali_pkg::OP_REMOVE: begin
          if (is_empty) begin
            rsp_next.status = ali_pkg::ST_EMPTY;
          end else begin
            count_next = count - CW'(1);
          end
        end
        ali_pkg::OP_READ: begin
          if (!pos_lt_cnt) begin
            rsp_next.status = ali_pkg::ST_INDEX;
          end else begin
            rsp_next.word_out = rd_data;
          end
        end
        ali_pkg::OP_WRITE: begin
          if (!pos_lt_cnt) begin
            rsp_next.status = ali_pkg::ST_INDEX;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = pos_a;
          end
        end
        ali_pkg::OP_INSERT: begin
          if (!pos_le_cnt) begin
            rsp_next.status = ali_pkg::ST_INDEX;
          end else if (is_full) begin
            rsp_next.status = ali_pkg::ST_FULL;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = pos_a;
            count_next = count + CW'(1);
          end
        end
        ali_pkg::OP_ERASE: begin
          if (is_empty) begin
            rsp_next.status = ali_pkg::ST_EMPTY;
          end else if (!pos_lt_cnt) begin
            rsp_next.status = ali_pkg::ST_INDEX;
          end else begin
            count_next = count - CW'(1);
          end
        end
        default: begin
        end
      endcase
      rsp_next.count_now = 9'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= req;
    end
    wptr <= wptr_next;
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/array_list_insert_erase.sv @@
`default_nettype none
// Ordered list of up to DEPTH signed 32-bit words held in a single-port-write
// memory, with one operation in flight at a time. Every request gives one
// response with the read word, the count afterwards and a status. Append,
// remove last, read, write, any rejected request, and an insert or erase that
// moves no entry are committed from the execute state; an insert or erase
// that moves n entries (n at least one) first passes through the shift state,
// where each move is one read and one write through the element memory. A new
// request is taken as soon as the previous response is in the output register,
// even while that response waits to be transferred.
module array_list_insert_erase #(
  parameter int unsigned DEPTH = ali_pkg::DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire ali_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output ali_pkg::rsp_t      rsp
);

  ali_pkg::cmd_t  cmd;
  ali_pkg::stat_t stat;

  ali_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ali_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`default_nettype none
module tb;
  import ali_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int N_RANDOM   = 1450;
  localparam int LIMIT      = (N_RANDOM + 100) * (DEPTH + 40) * 4;
  localparam int QUIET_FROM = 4000;
  localparam int QUIET_TO   = 9000;
  localparam int HOLD_LEN   = 300;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct {
    bit   drain_first;  // wait until every response is back before offering
    req_t r;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  array_list_insert_erase dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #10 clk = ~clk;

  int    cyc = 0;
  int    errors = 0;
  int    hold_left = 0;
  int    n_checked = 0;
  int    peak_len = 0;
  int    status_seen [4];
  int    gen_len = 0;
  int    n_rand = 0;
  bit    in_random = 1'b0;
  stim_t pending [$];
  rsp_t  expected_rsp [$];
  stim_t next_stim;
  rsp_t  want;

  // shadow of the list contents
  logic signed [31:0] list_words [DEPTH];
  int                 list_len = 0;

  function automatic status_t op_status(int len, req_t r);
    case (r.opcode)
      OP_APPEND: return (len >= DEPTH) ? ST_FULL : ST_OK;
      OP_REMOVE: return (len == 0) ? ST_EMPTY : ST_OK;
      OP_READ, OP_WRITE: return (r.position >= len) ? ST_INDEX : ST_OK;
      // position check wins over full
      OP_INSERT: begin
        if (r.position > len) return ST_INDEX;
        return (len >= DEPTH) ? ST_FULL : ST_OK;
      end
      OP_ERASE: begin
        if (len == 0) return ST_EMPTY;
        return (r.position >= len) ? ST_INDEX : ST_OK;
      end
      default: return ST_OK;
    endcase
  endfunction

  function automatic int len_after(int len, req_t r);
    if (op_status(len, r) != ST_OK) return len;
    case (r.opcode)
      OP_APPEND, OP_INSERT: return len + 1;
      OP_REMOVE, OP_ERASE:  return len - 1;
      default:              return len;
    endcase
  endfunction

  function automatic rsp_t list_response(req_t r);
    rsp_t    o;
    status_t st;
    int      p;
    st = op_status(list_len, r);
    p = r.position;
    o = '0;
    if (st == ST_OK) begin
      case (r.opcode)
        OP_APPEND: list_words[list_len] = r.word_in;
        OP_READ:   o.word_out = list_words[p];
        OP_WRITE:  list_words[p] = r.word_in;
        OP_INSERT: begin
          for (int i = list_len; i > p; i--) list_words[i] = list_words[i - 1];
          list_words[p] = r.word_in;
        end
        OP_ERASE: begin
          for (int i = p; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
        end
        default: ;
      endcase
    end
    list_len = len_after(list_len, r);
    o.count_now = 9'(list_len);
    o.status = st;
    return o;
  endfunction

  function automatic bit take_gap();
    return (cyc < QUIET_FROM || cyc >= QUIET_TO) && ($urandom_range(99) < 10);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic add(input logic [2:0] op, input int pos, input logic [31:0] w,
                     input bit drain_first);
    stim_t s;
    s.drain_first = drain_first;
    s.r.opcode = op;
    s.r.position = pos[7:0];
    s.r.word_in = w;
    pending.insert(pending.size(), s);
    gen_len = len_after(gen_len, s.r);
    if (in_random) n_rand++;
  endtask

  // position mostly inside the list, sometimes anywhere
  function automatic int pick_pos(logic [2:0] op);
    int top;
    if ($urandom_range(99) < 15) return $urandom_range(255);
    top = (op == OP_INSERT) ? gen_len : gen_len - 1;
    if (top > 255) top = 255;
    if (top < 0) top = 0;
    return $urandom_range(top);
  endfunction

  task automatic add_mixed(input bit drain_first);
    logic [2:0] op;
    if ($urandom_range(99) < 8) begin
      add(3'($urandom_range(7)), $urandom_range(255), $urandom, drain_first);
    end else begin
      op = 3'($urandom_range(5));
      add(op, pick_pos(op), pick_word(), drain_first);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (pending.size() != 0 && !take_gap() &&
          !(pending[0].drain_first && (req_valid || expected_rsp.size() != 0))) begin
        next_stim = pending.pop_front();
        req_valid <= 1'b1;
        req <= next_stim.r;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver, with two long hold-offs that back the list engine up
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (cyc == 1500 || cyc == 20000) begin
      rsp_ready <= 1'b0;
      hold_left <= HOLD_LEN;
    end else begin
      rsp_ready <= !take_gap();
    end
  end

  // check responses, then predict for the request taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $error("response transfer with no request outstanding");
          errors++;
        end else begin
          want = expected_rsp.pop_front();
          n_checked++;
          if (rsp.word_out !== want.word_out) begin
            $error("word_out: expected %0d, got %0d", want.word_out, rsp.word_out);
            errors++;
          end
          if (rsp.count_now !== want.count_now) begin
            $error("count_now: expected %0d, got %0d", want.count_now, rsp.count_now);
            errors++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errors++;
          end
        end
      end
      if (req_valid && req_ready) begin
        want = list_response(req);
        expected_rsp.insert(expected_rsp.size(), want);
        status_seen[want.status]++;
        if (list_len > peak_len) peak_len = list_len;
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int kind;

    // directed: empty-list errors, extremes, every opcode
    add(OP_REMOVE, 0, 0, 1'b0);
    add(OP_ERASE, 0, 0, 1'b0);
    add(OP_READ, 0, 0, 1'b0);
    add(OP_WRITE, 0, 32'h1111_1111, 1'b0);
    add(OP_INSERT, 1, 32'h2222_2222, 1'b0);
    add(OP_INSERT, 0, 32'h7fff_ffff, 1'b0);
    add(OP_APPEND, 0, 32'h8000_0000, 1'b0);
    add(OP_APPEND, 0, 32'hffff_ffff, 1'b0);
    add(OP_APPEND, 0, 32'h0, 1'b0);
    add(OP_INSERT, 4, 32'h1234_5678, 1'b0);  // at the end, acts as append
    add(OP_INSERT, 2, 32'h55aa_55aa, 1'b0);
    add(OP_READ, 0, 0, 1'b0);
    add(OP_READ, 5, 0, 1'b0);
    add(OP_WRITE, 3, 32'ha5a5_a5a5, 1'b0);
    add(OP_READ, 3, 0, 1'b0);
    add(OP_ERASE, 1, 0, 1'b0);
    add(OP_ERASE, 4, 0, 1'b0);
    add(OP_ERASE, 4, 0, 1'b0);
    add(OP_READ, 200, 0, 1'b0);
    add(OP_WRITE, 255, 32'hdead_beef, 1'b0);
    add(OP_INSERT, 255, 32'hcafe_f00d, 1'b0);
    add(OP_SPARE6, 255, 32'hffff_ffff, 1'b0);
    add(OP_SPARE7, 0, 32'h0, 1'b0);
    add(OP_READ, 2, 0, 1'b0);
    add(OP_REMOVE, 0, 0, 1'b0);

    in_random = 1'b1;
    kind = 0;
    while (n_rand < N_RANDOM) begin
      if (kind < 15) begin
        // fill to capacity, then poke the full list
        add(OP_APPEND, $urandom_range(255), pick_word(), 1'b1);
        while (gen_len < DEPTH) add(OP_APPEND, $urandom_range(255), pick_word(), 1'b0);
        add(OP_APPEND, 0, pick_word(), 1'b0);
        add(OP_INSERT, $urandom_range(255), pick_word(), 1'b0);
        add(OP_READ, 255, 0, 1'b0);
        add(OP_WRITE, $urandom_range(255), pick_word(), 1'b0);
        add(OP_INSERT, 255, pick_word(), 1'b0);
      end else if (kind < 28) begin
        // drain to empty, then once more on the empty list
        while (gen_len > 0) begin
          if ($urandom_range(1)) add(OP_REMOVE, $urandom_range(255), $urandom, 1'b0);
          else add(OP_ERASE, pick_pos(OP_ERASE), $urandom, 1'b0);
        end
        add($urandom_range(1) ? OP_REMOVE : OP_ERASE, $urandom_range(255), $urandom, 1'b0);
      end else begin
        add_mixed($urandom_range(9) == 0);
        repeat ($urandom_range(60, 20)) add_mixed(1'b0);
      end
      kind = $urandom_range(99);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || req_valid || expected_rsp.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);
    if (expected_rsp.size() != 0) begin
      $error("%0d responses never arrived", expected_rsp.size());
      errors++;
    end

    $display("%0d responses checked; list length reached %0d of %0d",
             n_checked, peak_len, DEPTH);
    $display("outcomes: ok %0d, bad index %0d, full %0d, empty %0d",
             status_seen[ST_OK], status_seen[ST_INDEX], status_seen[ST_FULL],
             status_seen[ST_EMPTY]);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
